@@ design/lpht_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the linear-probe hash table.
// No dependencies.
package lpht_pkg;

  localparam int NAME_W  = 64;
  localparam int DIST_W  = 8;
  localparam int POP_W   = 31;
  localparam int ELEV_W  = 16;
  localparam int OUT_W   = 5;   // width of index and count result fields

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  // slot status codes
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]               status;
    logic [NAME_W-1:0]        name;
    logic [DIST_W-1:0]        district;
    logic [POP_W-1:0]         population;
    logic signed [ELEV_W-1:0] elevation;
    logic                     municipality;
  } slot_entry_t;

endpackage

@@ design/lpht_slot_ram.sv @@
`timescale 1ns / 1ps
// Slot memory: one write port, one read port, registered read data.
// Uses lpht_pkg for the entry layout.
module lpht_slot_ram #(
  parameter int DEPTH = 23,
  parameter int AW    = 5
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  lpht_pkg::slot_entry_t wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output lpht_pkg::slot_entry_t rdata_o
);

  lpht_pkg::slot_entry_t mem [DEPTH];
  lpht_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lpht_home.sv @@
`timescale 1ns / 1ps
// Home slot unit: byte sum of the key, then modulo SLOTS by reciprocal
// multiplication and one compare-and-subtract. Uses lpht_pkg.
module lpht_home #(
  parameter int SLOTS     = 23,
  parameter int KEY_BYTES = 5,
  parameter int IDX_W     = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpht_pkg::NAME_W-1:0] name_i,
  output logic                        done_o,
  output logic [IDX_W-1:0]            home_o
);

  localparam int SUM_MAX = KEY_BYTES * 255;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int SLOT_W  = $clog2(SLOTS + 1);
  // floor(2^SUM_W / SLOTS): quotient estimate is exact or one short
  localparam int RECIP   = (1 << SUM_W) / SLOTS;
  localparam int RECIP_W = $clog2(RECIP + 2);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int CMP_W   = SUM_W + SLOT_W;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  quot_q;
  logic [IDX_W-1:0]  home_q;
  logic              mul_q;
  logic              sub_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  qs;
  logic [CMP_W-1:0]  rem;
  logic [CMP_W-1:0]  rem_fix;

  // name is already cut at its first zero byte, so trailing zeros add nothing
  always_comb begin
    sum = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      sum = sum + SUM_W'(name_i[8*i +: 8]);
    end
  end

  assign prod    = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign qs      = CMP_W'(quot_q) * CMP_W'(SLOTS);
  assign rem     = CMP_W'(sum_q) - qs;
  assign rem_fix = (rem >= CMP_W'(SLOTS)) ? (rem - CMP_W'(SLOTS)) : rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      quot_q <= '0;
      home_q <= '0;
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
      if (start_i) begin
        sum_q <= sum;
      end
      if (mul_q) begin
        quot_q <= SUM_W'(prod >> SUM_W);
      end
      if (sub_q) begin
        home_q <= IDX_W'(rem_fix);
      end
    end
  end

  assign done_o = done_q;
  assign home_o = home_q;

endmodule

@@ design/linear_probe_hash_table_core.sv @@
`timescale 1ns / 1ps
// Linear-probe hash table of town records, keyed by an 8-byte name.
// Input channel: in_valid_i / in_stall_o with func_i (0 insert, 1 search,
//   2 delete), name_i and the record fields stored on insert.
// Output channel: out_valid_o / out_stall_i, one result word per input word.
// Per word: an accept step, the home slot (byte sum, reciprocal multiply,
//   remainder fix-up), one probed slot at a time (1 to SLOTS slots), and
//   the result handover. A full-table insert or func 3 skips the home slot
//   and the probe walk. The probe walk is bound by the single read port of
//   the slot memory.
// One word is in flight at a time; a new word is taken while the previous
//   result still waits at the output register.
// Reset: a clearing pass marks every slot empty, one slot after another;
//   in_stall_o is high during it. Occupied count resets to zero.
// A stalled output holds its word; a finished result then waits inside the
//   block and no new input is taken until it moves out.
module linear_probe_hash_table_core #(
  parameter int SLOTS     = 23,
  parameter int KEY_BYTES = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         func_i,
  input  logic [lpht_pkg::NAME_W-1:0]        name_i,
  input  logic [lpht_pkg::DIST_W-1:0]        district_code_i,
  input  logic [lpht_pkg::POP_W-1:0]         population_i,
  input  logic signed [lpht_pkg::ELEV_W-1:0] elevation_i,
  input  logic                               has_municipality_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [lpht_pkg::OUT_W-1:0]         slot_index_o,
  output logic [lpht_pkg::OUT_W-1:0]         collisions_o,
  output logic [lpht_pkg::DIST_W-1:0]        found_district_o,
  output logic [lpht_pkg::POP_W-1:0]         found_population_o,
  output logic signed [lpht_pkg::ELEV_W-1:0] found_elevation_o,
  output logic                               found_municipality_o,
  output logic [lpht_pkg::OUT_W-1:0]         entries_used_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  function automatic logic [lpht_pkg::NAME_W-1:0] canon(
    input logic [lpht_pkg::NAME_W-1:0] n
  );
    logic                        keep;
    logic [lpht_pkg::NAME_W-1:0] r;
    keep = 1'b1;
    r    = '0;
    for (int i = 0; i < 8; i++) begin
      if (n[8*i +: 8] == 8'd0) keep = 1'b0;
      if (keep) r[8*i +: 8] = n[8*i +: 8];
    end
    return r;
  endfunction

  logic [2:0]                        state_q;
  logic [IDX_W-1:0]                  clr_q;
  logic [CNT_W-1:0]                  occ_q;
  logic [1:0]                        func_q;
  logic [lpht_pkg::NAME_W-1:0]       name_q;
  logic [lpht_pkg::DIST_W-1:0]       dist_q;
  logic [lpht_pkg::POP_W-1:0]        pop_q;
  logic signed [lpht_pkg::ELEV_W-1:0] elev_q;
  logic                              muni_q;
  logic [IDX_W-1:0]                  idx_q;
  logic [IDX_W-1:0]                  home_q;
  logic [CNT_W-1:0]                  col_q;
  logic [1:0]                        res_status_q;
  logic [IDX_W-1:0]                  res_slot_q;
  logic [CNT_W-1:0]                  res_col_q;
  lpht_pkg::slot_entry_t             res_rec_q;
  logic                              out_valid_q;

  logic                  in_accept;
  logic                  hash_start;
  logic                  hash_done;
  logic [IDX_W-1:0]      hash_home;
  logic [IDX_W-1:0]      idx_next;
  logic                  wrap;
  logic                  is_ins;
  logic                  rd_free;
  logic                  rd_empty;
  logic                  rd_hit;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  lpht_pkg::slot_entry_t ram_wdata;
  lpht_pkg::slot_entry_t ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign hash_start = in_accept && (func_i != lpht_pkg::FUNC_NONE) &&
                      !((func_i == lpht_pkg::FUNC_INSERT) && (occ_q >= CNT_W'(SLOTS)));

  lpht_home #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES),
    .IDX_W     (IDX_W)
  ) u_home (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .name_i  (canon(name_i)),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  lpht_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One read per probe cycle; the write ends the probe, so a read never
  // meets a pending write to the same slot.
  always_comb begin
    idx_next = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
    wrap     = (idx_next == home_q);
    is_ins   = (func_q == lpht_pkg::FUNC_INSERT);
    rd_empty = (ram_rdata.status == lpht_pkg::SLOT_EMPTY);
    rd_free  = rd_empty || (ram_rdata.status == lpht_pkg::SLOT_DELETED);
    rd_hit   = (ram_rdata.status == lpht_pkg::SLOT_USED) && (ram_rdata.name == name_q);

    ram_we                 = 1'b0;
    ram_waddr              = idx_q;
    ram_raddr              = idx_next;
    ram_wdata.status       = lpht_pkg::SLOT_USED;
    ram_wdata.name         = name_q;
    ram_wdata.district     = dist_q;
    ram_wdata.population   = pop_q;
    ram_wdata.elevation    = elev_q;
    ram_wdata.municipality = muni_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we           = 1'b1;
        ram_waddr        = clr_q;
        ram_wdata.status = lpht_pkg::SLOT_EMPTY;
      end
      ST_HASH: begin
        ram_raddr = hash_home;
      end
      ST_PROBE: begin
        if (is_ins) begin
          ram_we = rd_free;
        end else if (rd_hit && (func_q == lpht_pkg::FUNC_DELETE)) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata;
          ram_wdata.status = lpht_pkg::SLOT_DELETED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= ST_CLEAR;
      clr_q                <= '0;
      occ_q                <= '0;
      func_q               <= '0;
      name_q               <= '0;
      dist_q               <= '0;
      pop_q                <= '0;
      elev_q               <= '0;
      muni_q               <= 1'b0;
      idx_q                <= '0;
      home_q               <= '0;
      col_q                <= '0;
      res_status_q         <= '0;
      res_slot_q           <= '0;
      res_col_q            <= '0;
      res_rec_q            <= '0;
      out_valid_q          <= 1'b0;
      status_o             <= '0;
      slot_index_o         <= '0;
      collisions_o         <= '0;
      found_district_o     <= '0;
      found_population_o   <= '0;
      found_elevation_o    <= '0;
      found_municipality_o <= 1'b0;
      entries_used_o       <= '0;
    end else begin
      // in ST_DONE the output register is handled by the load below
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            func_q       <= func_i;
            name_q       <= canon(name_i);
            dist_q       <= district_code_i;
            pop_q        <= population_i;
            elev_q       <= elevation_i;
            muni_q       <= has_municipality_i;
            res_status_q <= lpht_pkg::RES_MISS;
            res_slot_q   <= '0;
            res_col_q    <= '0;
            res_rec_q    <= '0;
            if (hash_start) begin
              state_q <= ST_HASH;
            end else begin
              if (func_i == lpht_pkg::FUNC_INSERT) begin
                res_status_q <= lpht_pkg::RES_FULL;
              end
              state_q <= ST_DONE;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            idx_q   <= hash_home;
            home_q  <= hash_home;
            col_q   <= '0;
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (is_ins && rd_free) begin
            res_status_q <= lpht_pkg::RES_OK;
            res_slot_q   <= idx_q;
            res_col_q    <= col_q;
            occ_q        <= occ_q + 1'b1;
            state_q      <= ST_DONE;
          end else if (!is_ins && rd_empty) begin
            res_col_q <= col_q;
            state_q   <= ST_DONE;
          end else if (!is_ins && rd_hit) begin
            res_status_q <= lpht_pkg::RES_OK;
            res_slot_q   <= idx_q;
            res_col_q    <= col_q;
            res_rec_q    <= ram_rdata;
            if ((func_q == lpht_pkg::FUNC_DELETE) && (occ_q != '0)) begin
              occ_q <= occ_q - 1'b1;
            end
            state_q <= ST_DONE;
          end else if (wrap) begin
            res_col_q <= col_q + 1'b1;
            state_q   <= ST_DONE;
          end else begin
            col_q <= col_q + 1'b1;
            idx_q <= idx_next;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q          <= 1'b1;
            status_o             <= res_status_q;
            slot_index_o         <= lpht_pkg::OUT_W'(res_slot_q);
            collisions_o         <= lpht_pkg::OUT_W'(res_col_q);
            found_district_o     <= res_rec_q.district;
            found_population_o   <= res_rec_q.population;
            found_elevation_o    <= res_rec_q.elevation;
            found_municipality_o <= res_rec_q.municipality;
            entries_used_o       <= lpht_pkg::OUT_W'(occ_q);
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // no slot memory write while the block is open for a new word
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !ram_we)
    else $error("slot write while idle");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(SLOTS))
    else $error("occupied count above table size");

  // a write during the probe walk always closes the walk
  a_write_ends_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == ST_PROBE)) |=> (state_q == ST_DONE))
    else $error("probe continued after write-back");

  a_occ_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> ($past(ram_we) && ($past(state_q) == ST_PROBE)))
    else $error("occupied count moved without a slot write");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> ((idx_q < IDX_W'(SLOTS - 1)) || (idx_q == IDX_W'(SLOTS - 1))))
    else $error("probe index beyond table");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_table_core: directed rows first, then phased random
// insert/search/delete traffic, results checked against a model table or typed rows.
// Depends on lpht_pkg and the core RTL.
module tb;

  localparam int SLOTS       = 23;
  localparam int KEY_BYTES   = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 28;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 113;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [1:0]                         status;
    logic [lpht_pkg::OUT_W-1:0]         slot;
    logic [lpht_pkg::OUT_W-1:0]         coll;
    logic [lpht_pkg::DIST_W-1:0]        district;
    logic [lpht_pkg::POP_W-1:0]         population;
    logic signed [lpht_pkg::ELEV_W-1:0] elevation;
    logic                               municipality;
    logic [lpht_pkg::OUT_W-1:0]         used;
  } town_result_t;

  typedef struct {
    logic [1:0]                         func;
    logic [lpht_pkg::NAME_W-1:0]        name;
    logic [lpht_pkg::DIST_W-1:0]        district;
    logic [lpht_pkg::POP_W-1:0]         population;
    logic signed [lpht_pkg::ELEV_W-1:0] elevation;
    logic                               municipality;
    bit                                 typed;
    town_result_t                       res;
  } dir_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid;
  logic                                in_stall_o;
  logic [1:0]                          word_func;
  logic [lpht_pkg::NAME_W-1:0]         word_name;
  logic [lpht_pkg::DIST_W-1:0]         word_district;
  logic [lpht_pkg::POP_W-1:0]          word_population;
  logic signed [lpht_pkg::ELEV_W-1:0]  word_elevation;
  logic                                word_municipality;
  logic                                out_valid_o;
  logic                                out_stall;
  logic [1:0]                          status_o;
  logic [lpht_pkg::OUT_W-1:0]          slot_index_o;
  logic [lpht_pkg::OUT_W-1:0]          collisions_o;
  logic [lpht_pkg::DIST_W-1:0]         found_district_o;
  logic [lpht_pkg::POP_W-1:0]          found_population_o;
  logic signed [lpht_pkg::ELEV_W-1:0]  found_elevation_o;
  logic                                found_municipality_o;
  logic [lpht_pkg::OUT_W-1:0]          entries_used_o;

  // behavioral copy of the table
  lpht_pkg::slot_entry_t       town_slots [SLOTS];
  int                          town_count;
  logic [lpht_pkg::NAME_W-1:0] name_pool [POOL_SIZE];
  dir_row_t                    dir_rows [$];
  town_result_t                pending_results [$];
  int                          mismatches;
  bit                          quiet;
  bit                          hold_req;

  linear_probe_hash_table_core #(
    .SLOTS    (SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .func_i              (word_func),
    .name_i              (word_name),
    .district_code_i     (word_district),
    .population_i        (word_population),
    .elevation_i         (word_elevation),
    .has_municipality_i  (word_municipality),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .status_o            (status_o),
    .slot_index_o        (slot_index_o),
    .collisions_o        (collisions_o),
    .found_district_o    (found_district_o),
    .found_population_o  (found_population_o),
    .found_elevation_o   (found_elevation_o),
    .found_municipality_o(found_municipality_o),
    .entries_used_o      (entries_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // bytes after the first zero byte do not belong to the name
  function automatic logic [lpht_pkg::NAME_W-1:0] canon_name(
    input logic [lpht_pkg::NAME_W-1:0] n);
    logic [lpht_pkg::NAME_W-1:0] r;
    bit cut;
    r = '0;
    cut = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (n[8*i +: 8] == 8'd0) cut = 1'b1;
      if (!cut) r[8*i +: 8] = n[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int home_of(input logic [lpht_pkg::NAME_W-1:0] n);
    int sum;
    bit cut;
    sum = 0;
    cut = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (n[8*i +: 8] == 8'd0) cut = 1'b1;
      if (!cut) sum += n[8*i +: 8];
    end
    return sum % SLOTS;
  endfunction

  function automatic town_result_t mk_res(input logic [1:0] st, input int slot, input int coll,
                                          input logic [lpht_pkg::DIST_W-1:0] d,
                                          input logic [lpht_pkg::POP_W-1:0] p,
                                          input logic signed [lpht_pkg::ELEV_W-1:0] e,
                                          input logic m, input int used);
    town_result_t r;
    r.status       = st;
    r.slot         = slot[lpht_pkg::OUT_W-1:0];
    r.coll         = coll[lpht_pkg::OUT_W-1:0];
    r.district     = d;
    r.population   = p;
    r.elevation    = e;
    r.municipality = m;
    r.used         = used[lpht_pkg::OUT_W-1:0];
    return r;
  endfunction

  // applies one operation to the model table and returns the result word it yields
  function automatic town_result_t predict_town_op(input logic [1:0] f,
                                                   input logic [lpht_pkg::NAME_W-1:0] raw,
                                                   input logic [lpht_pkg::DIST_W-1:0] d,
                                                   input logic [lpht_pkg::POP_W-1:0] p,
                                                   input logic signed [lpht_pkg::ELEV_W-1:0] e,
                                                   input logic m);
    town_result_t r;
    logic [lpht_pkg::NAME_W-1:0] n;
    int start, i, c;
    bit done, hit;
    r = '0;
    r.status = lpht_pkg::RES_MISS;
    n = canon_name(raw);
    start = home_of(n);
    i = start;
    c = 0;
    done = 1'b0;
    hit = 1'b0;
    case (f)
      lpht_pkg::FUNC_INSERT: begin
        if (town_count >= SLOTS) begin
          r.status = lpht_pkg::RES_FULL;
        end else begin
          while (!done) begin
            if (town_slots[i].status == lpht_pkg::SLOT_EMPTY ||
                town_slots[i].status == lpht_pkg::SLOT_DELETED) begin
              town_slots[i].status       = lpht_pkg::SLOT_USED;
              town_slots[i].name         = n;
              town_slots[i].district     = d;
              town_slots[i].population   = p;
              town_slots[i].elevation    = e;
              town_slots[i].municipality = m;
              town_count++;
              r.status = lpht_pkg::RES_OK;
              r.slot   = i[lpht_pkg::OUT_W-1:0];
              r.coll   = c[lpht_pkg::OUT_W-1:0];
              done = 1'b1;
            end else begin
              c++;
              i = (i + 1) % SLOTS;
              if (i == start) begin
                r.coll = c[lpht_pkg::OUT_W-1:0];
                done = 1'b1;
              end
            end
          end
        end
      end
      lpht_pkg::FUNC_SEARCH, lpht_pkg::FUNC_DELETE: begin
        // tombstones and other names are stepped over; an empty slot ends the walk
        while (!done && town_slots[i].status != lpht_pkg::SLOT_EMPTY) begin
          if (town_slots[i].status == lpht_pkg::SLOT_USED && town_slots[i].name == n) begin
            hit = 1'b1;
            done = 1'b1;
          end else begin
            c++;
            i = (i + 1) % SLOTS;
            if (i == start) done = 1'b1;
          end
        end
        r.coll = c[lpht_pkg::OUT_W-1:0];
        if (hit) begin
          r.status       = lpht_pkg::RES_OK;
          r.slot         = i[lpht_pkg::OUT_W-1:0];
          r.district     = town_slots[i].district;
          r.population   = town_slots[i].population;
          r.elevation    = town_slots[i].elevation;
          r.municipality = town_slots[i].municipality;
          if (f == lpht_pkg::FUNC_DELETE) begin
            town_slots[i].status = lpht_pkg::SLOT_DELETED;
            if (town_count > 0) town_count--;
          end
        end
      end
      default: ;
    endcase
    r.used = town_count[lpht_pkg::OUT_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] f, input logic [lpht_pkg::NAME_W-1:0] n,
                         input logic [lpht_pkg::DIST_W-1:0] d,
                         input logic [lpht_pkg::POP_W-1:0] p,
                         input logic signed [lpht_pkg::ELEV_W-1:0] e, input logic m,
                         input bit typed, input town_result_t res);
    dir_row_t row;
    row.func = f;
    row.name = n;
    row.district = d;
    row.population = p;
    row.elevation = e;
    row.municipality = m;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // drives one word from the falling edge and waits for it to be taken
  task automatic offer_word(input logic [1:0] f, input logic [lpht_pkg::NAME_W-1:0] n,
                            input logic [lpht_pkg::DIST_W-1:0] d,
                            input logic [lpht_pkg::POP_W-1:0] p,
                            input logic signed [lpht_pkg::ELEV_W-1:0] e, input logic m,
                            input bit typed, input town_result_t want);
    town_result_t r;
    @(negedge clk_i);
    in_valid          = 1'b1;
    word_func         = f;
    word_name         = n;
    word_district     = d;
    word_population   = p;
    word_elevation    = e;
    word_municipality = m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_town_op(f, n, d, p, e, m);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic gap_in(input int cycles);
    @(negedge clk_i);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // a pool name, sometimes with junk after its terminating zero byte
  function automatic logic [lpht_pkg::NAME_W-1:0] pool_name();
    logic [lpht_pkg::NAME_W-1:0] n;
    int len;
    n = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    len = 8;
    for (int i = 7; i >= 0; i--) if (n[8*i +: 8] == 8'd0) len = i;
    if (len < 7 && $urandom_range(0, 2) == 0)
      for (int i = len + 1; i < 8; i++) n[8*i +: 8] = 8'($urandom);
    return n;
  endfunction

  // kind 0 fills the table, 1 mixes, 2 drains it
  task automatic random_phase(input int kind, input int count);
    int r, ti, ts, td;
    logic [1:0] f;
    logic [lpht_pkg::NAME_W-1:0] n;
    case (kind)
      0:       begin ti = 75; ts = 90; td = 98; end
      1:       begin ti = 35; ts = 70; td = 98; end
      default: begin ti = 15; ts = 45; td = 98; end
    endcase
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      f = (r < ti) ? lpht_pkg::FUNC_INSERT : (r < ts) ? lpht_pkg::FUNC_SEARCH :
          (r < td) ? lpht_pkg::FUNC_DELETE : lpht_pkg::FUNC_NONE;
      // inserts stay in the pool so the table can be drained again
      if (f == lpht_pkg::FUNC_INSERT || $urandom_range(0, 3) != 0) n = pool_name();
      else n = {$urandom, $urandom};
      if (!quiet && $urandom_range(0, 4) == 0) gap_in($urandom_range(1, 7));
      offer_word(f, n, lpht_pkg::DIST_W'($urandom), lpht_pkg::POP_W'($urandom),
                 lpht_pkg::ELEV_W'($urandom), 1'($urandom), 1'b0, '0);
    end
  endtask

  // output stall driver, with one long hold when asked
  initial begin : stall_drive
    int burst;
    bit held;
    out_stall = 1'b0;
    burst = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        held = 1'b1;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 6);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    town_result_t act, want;
    if (rst_ni && out_valid_o && !out_stall) begin
      act = mk_res(status_o, slot_index_o, collisions_o, found_district_o, found_population_o,
                   found_elevation_o, found_municipality_o, entries_used_o);
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word, status %0d", act.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (act.status !== want.status || act.slot !== want.slot || act.coll !== want.coll ||
            act.district !== want.district || act.population !== want.population ||
            act.elevation !== want.elevation || act.municipality !== want.municipality ||
            act.used !== want.used) begin
          if (mismatches < 10) begin
            $display("mismatch (exp/act): status %0d/%0d slot %0d/%0d coll %0d/%0d",
                     want.status, act.status, want.slot, act.slot, want.coll, act.coll);
            $display("  district %0d/%0d pop %0d/%0d elev %0d/%0d muni %0d/%0d used %0d/%0d",
                     want.district, act.district, want.population, act.population,
                     want.elevation, act.elevation, want.municipality, act.municipality,
                     want.used, act.used);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [lpht_pkg::NAME_W-1:0] n;
    int len;
    rst_ni            = 1'b0;
    in_valid          = 1'b0;
    word_func         = lpht_pkg::FUNC_INSERT;
    word_name         = '0;
    word_district     = '0;
    word_population   = '0;
    word_elevation    = '0;
    word_municipality = 1'b0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    mismatches        = 0;
    town_count        = 0;
    for (int i = 0; i < SLOTS; i++) begin
      town_slots[i] = '0;
      town_slots[i].status = lpht_pkg::SLOT_EMPTY;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      len = $urandom_range(1, 8);
      n = '0;
      for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
      name_pool[i] = n;
    end

    // empty table, unused op, extremes of every field
    add_row(lpht_pkg::FUNC_SEARCH, 64'h41, 0, 0, 0, 0, 1,
            mk_res(lpht_pkg::RES_MISS, 0, 0, 0, 0, 0, 0, 0));
    add_row(lpht_pkg::FUNC_DELETE, 64'h41, 0, 0, 0, 0, 1,
            mk_res(lpht_pkg::RES_MISS, 0, 0, 0, 0, 0, 0, 0));
    add_row(lpht_pkg::FUNC_NONE, '1, 8'hFF, 31'h7FFF_FFFF, 16'sh7FFF, 1, 1,
            mk_res(lpht_pkg::RES_MISS, 0, 0, 0, 0, 0, 0, 0));
    add_row(lpht_pkg::FUNC_INSERT, '1, 8'hFF, 31'h7FFF_FFFF, 16'sh8000, 1, 1,
            mk_res(lpht_pkg::RES_OK, 10, 0, 0, 0, 0, 0, 1));
    add_row(lpht_pkg::FUNC_SEARCH, '1, 0, 0, 0, 0, 1,
            mk_res(lpht_pkg::RES_OK, 10, 0, 8'hFF, 31'h7FFF_FFFF, 16'sh8000, 1, 1));
    add_row(lpht_pkg::FUNC_INSERT, '0, 0, 0, 16'sh7FFF, 0, 1,
            mk_res(lpht_pkg::RES_OK, 0, 0, 0, 0, 0, 0, 2));
    add_row(lpht_pkg::FUNC_SEARCH, '0, 0, 0, 0, 0, 1,
            mk_res(lpht_pkg::RES_OK, 0, 0, 0, 0, 16'sh7FFF, 0, 2));
    // junk after the zero byte is dropped when stored and compared
    add_row(lpht_pkg::FUNC_INSERT, 64'hFFFF_FFFF_FFFF_0041, 8'h5A, 31'd12345, -16'sd1, 1, 1,
            mk_res(lpht_pkg::RES_OK, 19, 0, 0, 0, 0, 0, 3));
    add_row(lpht_pkg::FUNC_SEARCH, 64'h41, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_SEARCH, 64'h1234_0000_0000_0041, 0, 0, 0, 0, 0, '0);
    // duplicate and a colliding name
    add_row(lpht_pkg::FUNC_INSERT, 64'h41, 8'h11, 31'd7, 16'sd100, 0, 0, '0);
    add_row(lpht_pkg::FUNC_INSERT, 64'h2A17, 8'h22, 31'd8, -16'sd100, 1, 0, '0);
    // bytes past the key bytes only matter for the compare
    add_row(lpht_pkg::FUNC_INSERT, 64'h0102_0304_0506_0708, 8'h33, 31'd9, 16'sd5, 0, 0, '0);
    add_row(lpht_pkg::FUNC_INSERT, 64'h0902_0304_0506_0708, 8'h44, 31'd10, 16'sd6, 1, 0, '0);
    add_row(lpht_pkg::FUNC_SEARCH, 64'h0902_0304_0506_0708, 0, 0, 0, 0, 0, '0);
    // tombstones are skipped on search and reused on insert
    add_row(lpht_pkg::FUNC_DELETE, 64'h41, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_SEARCH, 64'h41, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_SEARCH, 64'h2A17, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_INSERT, 64'h2A17, 8'h55, 31'd11, 16'sd7, 0, 0, '0);
    add_row(lpht_pkg::FUNC_DELETE, '1, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_SEARCH, '1, 0, 0, 0, 0, 0, '0);
    add_row(lpht_pkg::FUNC_DELETE, 64'h42, 0, 0, 0, 0, 0, '0);
    // probe wraps from the last slot to the first
    add_row(lpht_pkg::FUNC_INSERT, 64'h5B, 8'h66, 31'd12, 16'sd8, 1, 0, '0);
    add_row(lpht_pkg::FUNC_INSERT, 64'h5B, 8'h77, 31'd13, 16'sd9, 0, 0, '0);
    add_row(lpht_pkg::FUNC_NONE, 64'h5B, 8'hA5, 31'h2AAA_AAAA, -16'sd2, 1, 0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k]) begin
      if ($urandom_range(0, 4) == 0) gap_in($urandom_range(1, 7));
      offer_word(dir_rows[k].func, dir_rows[k].name, dir_rows[k].district,
                 dir_rows[k].population, dir_rows[k].elevation, dir_rows[k].municipality,
                 dir_rows[k].typed, dir_rows[k].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) hold_req = 1'b1;
      if (ph == 5) begin
        // let the block drain completely before going on
        @(negedge clk_i);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (ph == PHASES - 1) quiet = 1'b1;
      random_phase(ph % 3, PHASE_WORDS);
    end
    @(negedge clk_i);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
